// ----- rtl/slbm_pkg.sv -----
// Package for the serial-loaded bank mapper: access codes, result codes,
// register indexes, memory sizes and the decode structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package slbm_pkg;

  localparam int PROG_RAM_DEPTH = 8192;
  localparam int CHAR_RAM_DEPTH = 8192;
  localparam int PROG_AW        = $clog2(PROG_RAM_DEPTH);
  localparam int CHAR_AW        = $clog2(CHAR_RAM_DEPTH);

  localparam int CFG_W       = 5;
  localparam int ROM_AW      = 18;
  localparam int SHIFT_LEN   = 5;

  typedef enum logic [1:0] {
    FUNC_CPU_READ   = 2'd0,
    FUNC_CPU_WRITE  = 2'd1,
    FUNC_PPU_READ   = 2'd2,
    FUNC_PPU_WRITE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    SRC_NONE     = 3'd0,
    SRC_RAM      = 3'd1,
    SRC_PROG_ROM = 3'd2,
    SRC_CHAR_ROM = 3'd3,
    SRC_WRITE    = 3'd4
  } source_t;

  typedef enum logic {
    CFG_PROG_BANKS = 1'b0,
    CFG_CHAR_BANKS = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    TGT_CONTROL   = 2'd0,
    TGT_CHAR_LOW  = 2'd1,
    TGT_CHAR_HIGH = 2'd2,
    TGT_PROG_BANK = 2'd3
  } target_t;

  // Result of decoding one access, carried to the read stage.
  typedef struct packed {
    logic                claimed;
    source_t             source;
    logic                ram_char;
    logic [ROM_AW-1:0]   rom_address;
    logic [1:0]          mirroring;
  } decode_t;

  // Memory strobes for one access.
  typedef struct packed {
    logic prog_we;
    logic char_we;
  } mem_op_t;

endpackage

`default_nettype wire

// ----- rtl/serial_loaded_bank_mapper.sv -----
// Serial-loaded bank mapper, top level. Uses slbm_pkg, slbm_ctrl, slbm_ram.
// An accepted item moves through the read stage (registered RAM data and
// decode) and then the output register; out_stall can hold both stages.
// Throughput: one item per cycle while in_stall is low; the single-port
// RAMs are read or written once per item in the accept cycle, and the read
// data is registered. Reset: synchronous; afterwards both 8K RAMs are zeroed,
// one entry per cycle, while in_stall is held high.
`timescale 1ns / 1ps
`default_nettype none

module serial_loaded_bank_mapper
  import slbm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        func,
  input  wire logic [15:0]       bus_address,
  input  wire logic [7:0]        write_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   claimed,
  output logic [2:0]             source,
  output logic [7:0]             ram_data,
  output logic [ROM_AW-1:0]      rom_address,
  output logic [1:0]             mirroring,
  input  wire logic              cfg_write,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  logic              clearing;
  logic [PROG_AW-1:0] clear_addr;
  logic              accept;
  logic              s1_valid, s1_advance;
  decode_t           dec, s1_dec;
  mem_op_t           mem_op;
  logic [7:0]        prog_rdata, char_rdata;
  logic              prog_we, char_we;
  logic [PROG_AW-1:0] prog_addr;
  logic [CHAR_AW-1:0] char_addr;
  logic [7:0]        wdata;

  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = clearing || (s1_valid && !s1_advance);
  assign accept     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + PROG_AW'(1);
      if (clear_addr == PROG_AW'(PROG_RAM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  slbm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .func        (func),
    .bus_address (bus_address),
    .write_value (write_value),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .dec         (dec),
    .mem_op      (mem_op)
  );

  assign prog_we   = clearing || (accept && mem_op.prog_we);
  assign char_we   = clearing || (accept && mem_op.char_we);
  assign prog_addr = clearing ? clear_addr : bus_address[PROG_AW-1:0];
  assign char_addr = clearing ? CHAR_AW'(clear_addr) : bus_address[CHAR_AW-1:0];
  assign wdata     = clearing ? 8'd0 : write_value;

  slbm_ram #(.DEPTH(PROG_RAM_DEPTH), .WIDTH(8)) u_prog_ram (
    .clk   (clk),
    .en    (accept),
    .we    (prog_we),
    .addr  (prog_addr),
    .wdata (wdata),
    .rdata (prog_rdata)
  );

  slbm_ram #(.DEPTH(CHAR_RAM_DEPTH), .WIDTH(8)) u_char_ram (
    .clk   (clk),
    .en    (accept),
    .we    (char_we),
    .addr  (char_addr),
    .wdata (wdata),
    .rdata (char_rdata)
  );

  // Read stage: the RAM data registers hold while this stage is stalled,
  // since no new item is accepted then.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_dec <= dec;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      claimed     <= s1_dec.claimed;
      source      <= s1_dec.source;
      rom_address <= s1_dec.rom_address;
      mirroring   <= s1_dec.mirroring;
      if (s1_dec.source == SRC_RAM) begin
        ram_data <= s1_dec.ram_char ? char_rdata : prog_rdata;
      end else begin
        ram_data <= 8'd0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/slbm_ram.sv -----
// Generic single-port synchronous RAM with registered read data.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module slbm_ram #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (en) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/slbm_ctrl.sv -----
// Mapper registers: serial shift loader, bank and control registers, the
// configuration registers and address decode/translation. Uses slbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slbm_ctrl
  import slbm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [1:0]        func,
  input  wire logic [15:0]       bus_address,
  input  wire logic [7:0]        write_value,
  input  wire logic              cfg_write,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  output decode_t                dec,
  output mem_op_t                mem_op
);

  logic [CFG_W-1:0] prog_bank_count;
  logic [CFG_W-1:0] char_bank_count;

  logic [4:0] shift_value, shift_value_next;
  logic [2:0] shift_count, shift_count_next;
  logic [4:0] control_bits, control_bits_next;
  logic [4:0] char_bank_low, char_bank_low_next;
  logic [4:0] char_bank_high, char_bank_high_next;
  logic [3:0] prog_bank_select, prog_bank_select_next;
  logic [1:0] mirror_mode, mirror_mode_next;

  logic       prog_ram_hit, rom_hit, video_hit, char_ram_mode, serial_write;
  logic [4:0] shifted;
  logic [3:0] last_bank;
  logic [4:0] count_minus_one;
  logic [ROM_AW-1:0] prog_addr, char_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      prog_bank_count <= CFG_W'(16);
      char_bank_count <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PROG_BANKS: prog_bank_count <= cfg_data;
        CFG_CHAR_BANKS: char_bank_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign prog_ram_hit  = (bus_address[15:13] == 3'b011);
  assign rom_hit       = bus_address[15];
  assign video_hit     = (bus_address[15:13] == 3'b000);
  assign char_ram_mode = (char_bank_count == '0);
  assign serial_write  = (func == FUNC_CPU_WRITE) && rom_hit;

  // Program translation; in 16K modes (control_bits[3:2] 2 or 3) bit 14 picks the low or high window.
  assign count_minus_one = prog_bank_count - CFG_W'(1);
  assign last_bank       = count_minus_one[3:0];

  always_comb begin
    case (control_bits[3:2])
      2'd2: begin
        if (!bus_address[14]) begin
          prog_addr = {4'd0, bus_address[13:0]};
        end else begin
          prog_addr = {prog_bank_select, bus_address[13:0]};
        end
      end
      2'd3: begin
        if (!bus_address[14]) begin
          prog_addr = {prog_bank_select, bus_address[13:0]};
        end else begin
          prog_addr = {last_bank, bus_address[13:0]};
        end
      end
      default: prog_addr = {prog_bank_select[3:1], bus_address[14:0]};
    endcase
  end

  always_comb begin
    if (!control_bits[4]) begin
      char_addr = {1'b0, char_bank_low[4:1], bus_address[12:0]};
    end else if (!bus_address[12]) begin
      char_addr = {1'b0, char_bank_low, bus_address[11:0]};
    end else begin
      char_addr = {1'b0, char_bank_high, bus_address[11:0]};
    end
  end

  // Decode of the access into a result and memory strobes.
  always_comb begin
    dec.claimed     = 1'b0;
    dec.source      = SRC_NONE;
    dec.ram_char    = 1'b0;
    dec.rom_address = '0;
    mem_op.prog_we  = 1'b0;
    mem_op.char_we  = 1'b0;
    case (func)
      FUNC_CPU_READ: begin
        if (prog_ram_hit) begin
          dec.claimed = 1'b1;
          dec.source  = SRC_RAM;
        end else if (rom_hit) begin
          dec.claimed     = 1'b1;
          dec.source      = SRC_PROG_ROM;
          dec.rom_address = prog_addr;
        end
      end
      FUNC_CPU_WRITE: begin
        if (prog_ram_hit || rom_hit) begin
          dec.claimed = 1'b1;
          dec.source  = SRC_WRITE;
        end
        mem_op.prog_we = prog_ram_hit;
      end
      FUNC_PPU_READ: begin
        if (video_hit) begin
          dec.claimed = 1'b1;
          if (char_ram_mode) begin
            dec.source   = SRC_RAM;
            dec.ram_char = 1'b1;
          end else begin
            dec.source      = SRC_CHAR_ROM;
            dec.rom_address = char_addr;
          end
        end
      end
      default: begin
        if (video_hit && char_ram_mode) begin
          dec.claimed    = 1'b1;
          dec.source     = SRC_WRITE;
          mem_op.char_we = 1'b1;
        end
      end
    endcase
    dec.mirroring = mirror_mode_next;
  end

  // Serial loader: one data bit per write, the fifth write commits.
  assign shifted = {write_value[0], shift_value[4:1]};

  always_comb begin
    shift_value_next      = shift_value;
    shift_count_next      = shift_count;
    control_bits_next     = control_bits;
    char_bank_low_next    = char_bank_low;
    char_bank_high_next   = char_bank_high;
    prog_bank_select_next = prog_bank_select;
    mirror_mode_next      = mirror_mode;
    if (serial_write) begin
      if (write_value[7]) begin
        shift_value_next  = '0;
        shift_count_next  = '0;
        control_bits_next = control_bits | 5'h0C;
      end else if (shift_count == 3'(SHIFT_LEN - 1)) begin
        shift_value_next = '0;
        shift_count_next = '0;
        case (target_t'(bus_address[14:13]))
          TGT_CONTROL: begin
            control_bits_next = shifted;
            mirror_mode_next  = shifted[1:0];
          end
          TGT_CHAR_LOW:  char_bank_low_next    = shifted;
          TGT_CHAR_HIGH: char_bank_high_next   = shifted;
          default:       prog_bank_select_next = shifted[3:0];
        endcase
      end else begin
        shift_value_next = shifted;
        shift_count_next = shift_count + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_value      <= '0;
      shift_count      <= '0;
      control_bits     <= 5'h1C;
      char_bank_low    <= '0;
      char_bank_high   <= '0;
      prog_bank_select <= '0;
      mirror_mode      <= 2'd3;
    end else if (accept) begin
      shift_value      <= shift_value_next;
      shift_count      <= shift_count_next;
      control_bits     <= control_bits_next;
      char_bank_low    <= char_bank_low_next;
      char_bank_high   <= char_bank_high_next;
      prog_bank_select <= prog_bank_select_next;
      mirror_mode      <= mirror_mode_next;
    end
  end

endmodule

`default_nettype wire
